// File: src/ppfov_pkg.sv
// Shared widths, constants and types for the pinhole projection block.
// Used by ppfov_axis, the top level pinhole_project_fov_check and the checker.
`default_nettype none

package ppfov_pkg;

   // Field widths
   localparam int COORD_W   = 32;               // Q16.16 coordinates
   localparam int ROT_W     = 18;               // Q2.16 rotation entry
   localparam int ROW_W     = 3 * ROT_W;        // packed rotation row
   localparam int PAIR_W    = 2 * COORD_W;      // packed x/y pair
   localparam int FOCAL_W   = 32;               // unsigned Q16.16 focal factor
   localparam int SHIFT_FRAC = 16;              // Q16.16 -> 32 fraction bits

   // Datapath widths
   localparam int PROD_W    = ROT_W + COORD_W;  // one rotation product
   localparam int CAM_W     = 52;               // camera-frame sum, signed
   localparam int MAG_W     = CAM_W - 1;        // magnitude of a camera sum
   localparam int HI_W      = MAG_W - FOCAL_W;  // upper slice of the magnitude
   localparam int PP_W      = MAG_W + FOCAL_W;  // magnitude times focal factor
   localparam int Q_W       = COORD_W + 1;      // quotient bits resolved

   // Pipeline: products, sums, abs, partial products, product sum,
   // overflow check, then one stage per quotient bit
   localparam int N_STAGES    = 6 + Q_W;
   localparam int FRONT_DEPTH = N_STAGES - 2;

   // Saturation limits
   localparam logic [Q_W-1:0]     Q_POS_LIMIT = 33'h0_7FFF_FFFF;
   localparam logic [Q_W-1:0]     Q_NEG_LIMIT = 33'h0_8000_0000;
   localparam logic [COORD_W-1:0] SAT_POS     = 32'h7FFF_FFFF;
   localparam logic [COORD_W-1:0] SAT_NEG     = 32'h8000_0000;

   // Register reset values
   localparam logic [ROW_W-1:0]  ROT_ROW0_RST = 54'h00_0000_0001_0000;
   localparam logic [ROW_W-1:0]  ROT_ROW1_RST = 54'h00_0004_0000_0000;
   localparam logic [ROW_W-1:0]  ROT_ROW2_RST = 54'h10_0000_0000_0000;
   localparam logic [PAIR_W-1:0] FOCAL_RST    = 64'h0001_0000_0001_0000;

   // Register map
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROT_ROW0    = 3'd0,
      CSR_ROT_ROW1    = 3'd1,
      CSR_ROT_ROW2    = 3'd2,
      CSR_SHIFT_XY    = 3'd3,
      CSR_SHIFT_Z     = 3'd4,
      CSR_FOCAL_PAIR  = 3'd5,
      CSR_HALF_EXTENT = 3'd6
   } ppfov_csr_type;

   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
   } ppfov_axis_in_type;

   typedef struct packed {
      logic [COORD_W-1:0] value;
      logic               in_window;
   } ppfov_axis_out_type;

   typedef struct packed {
      logic [COORD_W-1:0] image_u;
      logic [COORD_W-1:0] image_v;
      logic               in_front;
      logic               in_view;
   } ppfov_result_type;

endpackage

`default_nettype wire

// File: src/ppfov_axis.sv
// One image axis: magnitude times focal factor, pipelined restoring divide
// by depth, then saturation and window test. Depends on ppfov_pkg.
`default_nettype none

module ppfov_axis (
   input  logic                                clock,
   input  logic                                advance,
   input  ppfov_pkg::ppfov_axis_in_type        operand,
   input  logic [ppfov_pkg::MAG_W-1:0]         divisor,
   input  logic [ppfov_pkg::FOCAL_W-1:0]       focal,
   input  logic [ppfov_pkg::COORD_W-1:0]       half,
   output ppfov_pkg::ppfov_axis_out_type       result
);

   localparam int MagW = ppfov_pkg::MAG_W;
   localparam int FocW = ppfov_pkg::FOCAL_W;
   localparam int HiW  = ppfov_pkg::HI_W;
   localparam int PpW  = ppfov_pkg::PP_W;
   localparam int QW   = ppfov_pkg::Q_W;
   localparam int CrdW = ppfov_pkg::COORD_W;

   // partial products
   logic                  neg3_ff;
   logic [MagW-1:0]       den3_ff;
   logic [2*FocW-1:0]     plo3_ff;
   logic [HiW+FocW-1:0]   phi3_ff;

   // full product
   logic                  neg4_ff;
   logic [MagW-1:0]       den4_ff;
   logic [PpW-1:0]        prod4_ff;

   // divider lane; index 0 is the overflow check stage
   logic                  neg_ff [QW+1];
   logic                  ovf_ff [QW+1];
   logic [MagW-1:0]       den_ff [QW+1];
   logic [MagW-1:0]       rem_ff [QW+1];
   logic [QW-1:0]         lq_ff  [QW+1];

   logic [QW-1:0]         quo;
   logic [QW-1:0]         half_ext;
   logic                  exact;
   logic                  sat;
   logic [CrdW-1:0]       value;
   logic                  in_window;

   always_ff @(posedge clock) begin
      if (advance) begin
         neg3_ff  <= operand.neg;
         den3_ff  <= divisor;
         plo3_ff  <= operand.mag[FocW-1:0] * focal;
         phi3_ff  <= operand.mag[MagW-1:FocW] * focal;

         neg4_ff  <= neg3_ff;
         den4_ff  <= den3_ff;
         prod4_ff <= PpW'(plo3_ff) + {phi3_ff, {FocW{1'b0}}};

         // quotient of 2^Q_W or more saturates either way
         neg_ff[0] <= neg4_ff;
         den_ff[0] <= den4_ff;
         ovf_ff[0] <= MagW'(prod4_ff[PpW-1:QW]) >= den4_ff;
         rem_ff[0] <= MagW'(prod4_ff[PpW-1:QW]);
         lq_ff[0]  <= prod4_ff[QW-1:0];
      end
   end

   // One quotient bit per stage: dividend bits shift out of the top of lq,
   // quotient bits shift in at the bottom.
   for (genvar j = 1; j <= QW; j++) begin : g_step
      logic [MagW:0] trial;
      logic [MagW:0] diff;
      logic          fit;

      assign trial = {rem_ff[j-1], lq_ff[j-1][QW-1]};
      assign fit   = trial >= {1'b0, den_ff[j-1]};
      assign diff  = trial - {1'b0, den_ff[j-1]};

      always_ff @(posedge clock) begin
         if (advance) begin
            neg_ff[j] <= neg_ff[j-1];
            ovf_ff[j] <= ovf_ff[j-1];
            den_ff[j] <= den_ff[j-1];
            rem_ff[j] <= fit ? diff[MagW-1:0] : trial[MagW-1:0];
            lq_ff[j]  <= {lq_ff[j-1][QW-2:0], fit};
         end
      end
   end

   // Window test on the exact quotient; the negative side also admits
   // exactly -half, which needs a zero remainder.
   always_comb begin
      quo      = lq_ff[QW];
      half_ext = {1'b0, half};
      exact    = rem_ff[QW] == '0;
      if (neg_ff[QW]) begin
         sat       = ovf_ff[QW] || (quo > ppfov_pkg::Q_NEG_LIMIT);
         value     = sat ? ppfov_pkg::SAT_NEG : (~quo[CrdW-1:0] + 1'b1);
         in_window = !ovf_ff[QW] && ((quo < half_ext) || ((quo == half_ext) && exact));
      end else begin
         sat       = ovf_ff[QW] || (quo > ppfov_pkg::Q_POS_LIMIT);
         value     = sat ? ppfov_pkg::SAT_POS : quo[CrdW-1:0];
         in_window = !ovf_ff[QW] && (quo < half_ext);
      end
   end

   assign result.value     = value;
   assign result.in_window = in_window;

endmodule

`default_nettype wire

// File: src/pinhole_project_fov_check.sv
// Top level of the pinhole projection block with field-of-view flags.
// Depends on ppfov_pkg and ppfov_axis.
//
// Usage:
//   req channel: one world point (Q16.16 x, y, z) per transfer, taken when
//   req_valid is high and req_stall is low.
//   rsp channel: one result per point, in order: image_u/image_v (Q16.16
//   about the image center, saturated), in_front and in_view.
//   csr port: write csr_data to register csr_index when csr_write_en is
//   high; write only while no point is in flight.
// Throughput: one point per cycle, sustained while req_stall is low. Depth is set by the
//   restoring divider, one stage per quotient bit (33 stages), behind six
//   stages of transform, magnitude, focal multiply and overflow check.
// Reset: clears all valid bits and the skid stage; rotation returns to
//   identity, focal factors to 1.0, translation and half extents to 0.
// Stall: when rsp_stall holds a waiting result, the next result goes to a
//   skid register and the pipeline keeps moving that cycle; once the skid
//   register is full, req_stall rises and the pipeline holds until the
//   result transfer completes.
`default_nettype none

module pinhole_project_fov_check (
   input  logic                                     clock,
   input  logic                                     reset,

   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [ppfov_pkg::COORD_W-1:0]     req_point_x,
   input  logic signed [ppfov_pkg::COORD_W-1:0]     req_point_y,
   input  logic signed [ppfov_pkg::COORD_W-1:0]     req_point_z,

   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [ppfov_pkg::COORD_W-1:0]     rsp_image_u,
   output logic signed [ppfov_pkg::COORD_W-1:0]     rsp_image_v,
   output logic                                     rsp_in_front,
   output logic                                     rsp_in_view,

   input  logic                                     csr_write_en,
   input  logic [ppfov_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [ppfov_pkg::CSR_DATA_W-1:0]         csr_data
);

   localparam int CrdW   = ppfov_pkg::COORD_W;
   localparam int RotW   = ppfov_pkg::ROT_W;
   localparam int RowW   = ppfov_pkg::ROW_W;
   localparam int PairW  = ppfov_pkg::PAIR_W;
   localparam int ProdW  = ppfov_pkg::PROD_W;
   localparam int CamW   = ppfov_pkg::CAM_W;
   localparam int MagW   = ppfov_pkg::MAG_W;
   localparam int NStg   = ppfov_pkg::N_STAGES;
   localparam int FrontD = ppfov_pkg::FRONT_DEPTH;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [RowW-1:0]  rot_row_ff [3];
   logic [PairW-1:0] shift_xy_ff;
   logic [CrdW-1:0]  shift_z_ff;
   logic [PairW-1:0] focal_pair_ff;
   logic [PairW-1:0] half_extent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_row_ff[0]  <= ppfov_pkg::ROT_ROW0_RST;
         rot_row_ff[1]  <= ppfov_pkg::ROT_ROW1_RST;
         rot_row_ff[2]  <= ppfov_pkg::ROT_ROW2_RST;
         shift_xy_ff    <= '0;
         shift_z_ff     <= '0;
         focal_pair_ff  <= ppfov_pkg::FOCAL_RST;
         half_extent_ff <= '0;
      end else if (csr_write_en) begin
         unique case (ppfov_pkg::ppfov_csr_type'(csr_index))
            ppfov_pkg::CSR_ROT_ROW0:    rot_row_ff[0]  <= csr_data[RowW-1:0];
            ppfov_pkg::CSR_ROT_ROW1:    rot_row_ff[1]  <= csr_data[RowW-1:0];
            ppfov_pkg::CSR_ROT_ROW2:    rot_row_ff[2]  <= csr_data[RowW-1:0];
            ppfov_pkg::CSR_SHIFT_XY:    shift_xy_ff    <= csr_data;
            ppfov_pkg::CSR_SHIFT_Z:     shift_z_ff     <= csr_data[CrdW-1:0];
            ppfov_pkg::CSR_FOCAL_PAIR:  focal_pair_ff  <= csr_data;
            ppfov_pkg::CSR_HALF_EXTENT: half_extent_ff <= csr_data;
            default: ;   // unmapped index: drop the write
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline control: the whole pipeline moves while the skid register
   // is empty, so a stall never splits an item from its valid bit.
   // ---------------------------------------------------------------------
   logic                    advance;
   logic                    skid_valid_ff;
   logic [NStg-1:0]         valid_ff;
   logic [FrontD-1:0]       front_ff;
   logic                    front_in;

   assign advance   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[NStg-2:0], req_valid};
      end
   end

   // ---------------------------------------------------------------------
   // Stage 0: the nine rotation products
   // ---------------------------------------------------------------------
   logic signed [CrdW-1:0]  point [3];
   logic signed [RotW-1:0]  coef [3][3];
   logic signed [ProdW-1:0] prod_in [3][3];
   logic signed [ProdW-1:0] prod_ff [3][3];

   always_comb begin
      point[0] = req_point_x;
      point[1] = req_point_y;
      point[2] = req_point_z;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            coef[r][c]    = rot_row_ff[r][c*RotW +: RotW];
            prod_in[r][c] = coef[r][c] * point[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: camera-frame sums at 32 fraction bits, exact
   // ---------------------------------------------------------------------
   logic signed [CrdW-1:0] trans [3];
   logic signed [CamW-1:0] cam_in [3];
   logic signed [CamW-1:0] cam_ff [3];

   always_comb begin
      trans[0] = shift_xy_ff[CrdW-1:0];
      trans[1] = shift_xy_ff[PairW-1:CrdW];
      trans[2] = shift_z_ff;
      for (int r = 0; r < 3; r++) begin
         cam_in[r] = CamW'(prod_ff[r][0]) + CamW'(prod_ff[r][1])
                   + CamW'(prod_ff[r][2])
                   + (CamW'(trans[r]) <<< ppfov_pkg::SHIFT_FRAC);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cam_ff <= cam_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: sign and magnitude of x and y, depth test
   // ---------------------------------------------------------------------
   logic [CamW-1:0]                  abs_val [2];
   ppfov_pkg::ppfov_axis_in_type     opnd_in [2];
   ppfov_pkg::ppfov_axis_in_type     opnd_ff [2];
   logic [MagW-1:0]                  den_ff;

   always_comb begin
      for (int r = 0; r < 2; r++) begin
         abs_val[r]     = cam_ff[r][CamW-1] ? -cam_ff[r] : cam_ff[r];
         opnd_in[r].neg = cam_ff[r][CamW-1];
         opnd_in[r].mag = abs_val[r][MagW-1:0];
      end
      front_in = !cam_ff[2][CamW-1] && (cam_ff[2] != '0);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         opnd_ff  <= opnd_in;
         den_ff   <= cam_ff[2][MagW-1:0];
         front_ff <= {front_ff[FrontD-2:0], front_in};
      end
   end

   // ---------------------------------------------------------------------
   // Stages 3 onward: focal multiply and divide, one lane per axis
   // ---------------------------------------------------------------------
   ppfov_pkg::ppfov_axis_out_type axis_u;
   ppfov_pkg::ppfov_axis_out_type axis_v;

   ppfov_axis u_axis_u (
      .clock   (clock),
      .advance (advance),
      .operand (opnd_ff[0]),
      .divisor (den_ff),
      .focal   (focal_pair_ff[CrdW-1:0]),
      .half    (half_extent_ff[CrdW-1:0]),
      .result  (axis_u)
   );

   ppfov_axis u_axis_v (
      .clock   (clock),
      .advance (advance),
      .operand (opnd_ff[1]),
      .divisor (den_ff),
      .focal   (focal_pair_ff[PairW-1:CrdW]),
      .half    (half_extent_ff[PairW-1:CrdW]),
      .result  (axis_v)
   );

   // ---------------------------------------------------------------------
   // Result assembly: zero everything for a point at or behind the camera
   // ---------------------------------------------------------------------
   ppfov_pkg::ppfov_result_type pres;
   logic                        pres_valid;
   logic                        front_last;

   always_comb begin
      front_last    = front_ff[FrontD-1];
      pres_valid    = valid_ff[NStg-1];
      pres.in_front = front_last;
      pres.image_u  = front_last ? axis_u.value : '0;
      pres.image_v  = front_last ? axis_v.value : '0;
      pres.in_view  = front_last && axis_u.in_window && axis_v.in_window;
   end

   // ---------------------------------------------------------------------
   // Output register plus skid register
   // ---------------------------------------------------------------------
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        skid_valid_in;
   ppfov_pkg::ppfov_result_type rsp_data_ff;
   ppfov_pkg::ppfov_result_type skid_data_ff;
   logic                        out_take;

   assign out_take = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (skid_valid_ff) begin
         // drain the skid register first; the pipeline is held
         rsp_valid_in  = out_take ? 1'b1 : rsp_valid_ff;
         skid_valid_in = !out_take;
      end else begin
         rsp_valid_in  = out_take ? pres_valid : rsp_valid_ff;
         skid_valid_in = !out_take && pres_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         rsp_data_ff <= skid_valid_ff ? skid_data_ff : pres;
      end
      if (!skid_valid_ff) begin
         skid_data_ff <= pres;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_image_u  = rsp_data_ff.image_u;
   assign rsp_image_v  = rsp_data_ff.image_v;
   assign rsp_in_front = rsp_data_ff.in_front;
   assign rsp_in_view  = rsp_data_ff.in_view;

endmodule

`default_nettype wire

// File: src/ppfov_checker.sv
// Port-level checks for pinhole_project_fov_check, attached by bind.
// Depends only on the top level's ports and ppfov_pkg widths.
`default_nettype none

module ppfov_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_stall,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [ppfov_pkg::COORD_W-1:0]     rsp_image_u,
   input  logic [ppfov_pkg::COORD_W-1:0]     rsp_image_v,
   input  logic                              rsp_in_front,
   input  logic                              rsp_in_view
);

   // a point at or behind the camera carries no coordinates and no view flag
   a_behind_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_front |->
         (rsp_image_u == '0) && (rsp_image_v == '0) && !rsp_in_view)
      else $error("point behind camera reported with nonzero fields");

   // input back-pressure only while a result is waiting
   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req_stall without a pending result");

   // back-pressure starts only after a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("req_stall rose without a stalled result");

   // reset empties the output side
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("output side not cleared by reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_image_u) && $stable(rsp_image_v)
         && $stable(rsp_in_front) && $stable(rsp_in_view))
      else $error("stalled result changed");

endmodule

bind pinhole_project_fov_check ppfov_checker u_ppfov_checker (.*);

`default_nettype wire
